// File: src/crml_pkg.sv
// Package for the codepoint range map lookup block.
// Holds request codes, lookup FSM states, default sizes and field widths.
// No dependencies.
package crml_pkg;

    localparam int TABLE_DEPTH_DEF  = 8192;
    localparam int FLAG_DEPTH_DEF   = 256;
    localparam int DATA_DEPTH_DEF   = 65536;
    localparam int MAX_MAPPINGS_DEF = 18;

    localparam int CP_W    = 21;
    localparam int CNT_W   = 14;
    localparam int IDX_W   = 16;
    localparam int OUT_IDX_W = 13;
    localparam int MAPC_W  = 5;
    localparam int FLAG_W  = 16;
    localparam int SLOT_W  = 8;
    localparam int BYTE_W  = 8;
    localparam int INFO_W  = 50;

    typedef enum logic [1:0] {
        REQ_WR_ENTRY = 2'd0,
        REQ_WR_FLAG  = 2'd1,
        REQ_WR_BYTE  = 2'd2,
        REQ_LOOKUP   = 2'd3
    } req_type_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PROBE,
        ST_CMP,
        ST_INFO,
        ST_FLAG,
        ST_BYTE,
        ST_DECODE,
        ST_EMIT
    } state_t;

endpackage

// File: src/crml_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module crml_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// File: src/codepoint_range_map_lookup.sv
// Top level of the codepoint range map lookup block.
// Depends on crml_pkg and crml_ram.
//
//  channel | signals                         | direction
//  --------+---------------------------------+----------
//  request | valid, ready, req_type..flags   | in
//  result  | out_valid, out_ready, found..last | out
//  config  | cfg_we, cfg_data                | in
//
// A lookup is accepted, then each binary-search probe passes the probe
// (address), compare (read latency) and info (compare) states, over at most
// ceil(log2(n+1)) probes, n = min(entry_count, TABLE_DEPTH), plus a closing
// probe state when nothing matches. A hit then issues the flag read in the
// flag state, passes the byte (read) and decode states per mapping byte, the
// byte state alone when the entry has no mappings, and emits each result
// while out_ready is high. Read latency of the range and byte stores sets
// these steps. Reset clears the control state and entry_count; stores hold
// garbage until written. A stalled result holds the engine in the emit state.
module codepoint_range_map_lookup
    import crml_pkg::*;
#(
    parameter int TABLE_DEPTH  = TABLE_DEPTH_DEF,
    parameter int FLAG_DEPTH   = FLAG_DEPTH_DEF,
    parameter int DATA_DEPTH   = DATA_DEPTH_DEF,
    parameter int MAX_MAPPINGS = MAX_MAPPINGS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CNT_W-1:0]     cfg_data,
    input  logic                 valid,
    output logic                 ready,
    input  logic [1:0]           req_type,
    input  logic [IDX_W-1:0]     write_index,
    input  logic [CP_W-1:0]      code_point,
    input  logic [CP_W-1:0]      range_span,
    input  logic [MAPC_W-1:0]    map_count,
    input  logic [IDX_W-1:0]     data_offset,
    input  logic [SLOT_W-1:0]    flag_slot,
    input  logic [FLAG_W-1:0]    flag_word,
    input  logic [BYTE_W-1:0]    data_byte,
    input  logic [FLAG_W-1:0]    required_flags,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic                 found,
    output logic [OUT_IDX_W-1:0] entry_index,
    output logic                 flags_match,
    output logic [MAPC_W-1:0]    mapping_total,
    output logic                 has_codepoint,
    output logic [CP_W-1:0]      mapped_cp,
    output logic                 last
);
    localparam int TA_W = $clog2(TABLE_DEPTH) > 0 ? $clog2(TABLE_DEPTH) : 1;
    localparam int FA_W = $clog2(FLAG_DEPTH) > 0 ? $clog2(FLAG_DEPTH) : 1;
    localparam int DA_W = $clog2(DATA_DEPTH);
    localparam int N_W  = $clog2(TABLE_DEPTH + 1) + 1;
    localparam int U_W  = $clog2(DATA_DEPTH + 1);
    localparam int MM_W = $clog2(MAX_MAPPINGS + 1) + 1;

    // configuration
    logic [CNT_W-1:0] entry_count_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_count_reg <= '0;
        end
        else if (cfg_we)
        begin
            entry_count_reg <= cfg_data;
        end
    end

    // request decode
    logic      acc;
    req_type_t rt;
    assign acc = valid && ready;
    assign rt  = req_type_t'(req_type);

    logic we_tab, we_flag, we_byte;
    assign we_tab  = acc && rt == REQ_WR_ENTRY && 32'(write_index) < TABLE_DEPTH;
    assign we_flag = acc && rt == REQ_WR_FLAG  && 32'(write_index) < FLAG_DEPTH;
    assign we_byte = acc && rt == REQ_WR_BYTE  && 32'(write_index) < DATA_DEPTH;

    // engine registers
    state_t              state_reg, state_next;
    logic [CP_W-1:0]     cp_reg, cp_next;
    logic [FLAG_W-1:0]   req_reg, req_next;
    logic [N_W-1:0]      lo_reg, lo_next, hi_reg, hi_next;
    logic [N_W-1:0]      mid_reg, mid_next;
    logic [MM_W-1:0]     total_reg, total_next, k_reg, k_next;
    logic [DA_W-1:0]     addr_reg, addr_next;
    logic [U_W-1:0]      used_reg, used_next;
    logic [CP_W-1:0]     v_reg, v_next;
    logic                found_reg, found_next, fm_reg, fm_next;
    logic                has_reg, has_next, last_reg, last_next;
    logic [SLOT_W-1:0]   slot_reg, slot_next;
    logic [DA_W-1:0]     off_reg, off_next;

    // memories
    logic [TA_W-1:0]   tab_raddr;
    logic [CP_W-1:0]   start_rd;
    logic [INFO_W-1:0] info_rd;
    logic [FLAG_W-1:0] flag_rd;
    logic [BYTE_W-1:0] byte_rd;
    logic [INFO_W-1:0] info_wd;

    assign tab_raddr = TA_W'(mid_reg);
    assign info_wd = {flag_slot, data_offset, map_count, range_span};

    crml_ram #(.WIDTH(CP_W), .DEPTH(TABLE_DEPTH)) u_start (
        .clk(clk), .we(we_tab), .waddr(TA_W'(write_index)), .wdata(code_point),
        .raddr(tab_raddr), .rdata(start_rd)
    );
    crml_ram #(.WIDTH(INFO_W), .DEPTH(TABLE_DEPTH)) u_info (
        .clk(clk), .we(we_tab), .waddr(TA_W'(write_index)), .wdata(info_wd),
        .raddr(tab_raddr), .rdata(info_rd)
    );
    crml_ram #(.WIDTH(FLAG_W), .DEPTH(FLAG_DEPTH)) u_flag (
        .clk(clk), .we(we_flag), .waddr(FA_W'(write_index)), .wdata(flag_word),
        .raddr(FA_W'(slot_reg)), .rdata(flag_rd)
    );
    crml_ram #(.WIDTH(BYTE_W), .DEPTH(DATA_DEPTH)) u_byte (
        .clk(clk), .we(we_byte), .waddr(DA_W'(write_index)), .wdata(data_byte),
        .raddr(addr_reg), .rdata(byte_rd)
    );

    // search compare; end of range kept to 22 bits
    logic [CP_W:0] end_cp;
    assign end_cp = {1'b0, start_rd} + {1'b0, info_rd[CP_W-1:0]};

    logic [N_W-1:0] n_eff;
    assign n_eff = (32'(entry_count_reg) > TABLE_DEPTH) ? N_W'(TABLE_DEPTH)
                                                         : N_W'(entry_count_reg);

    logic [MAPC_W-1:0] cnt_raw;
    assign cnt_raw = info_rd[CP_W +: MAPC_W];

    logic [N_W:0] lohi;
    assign lohi = {1'b0, lo_reg} + {1'b0, hi_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cp_reg    <= cp_next;
        req_reg   <= req_next;
        lo_reg    <= lo_next;
        hi_reg    <= hi_next;
        mid_reg   <= mid_next;
        total_reg <= total_next;
        k_reg     <= k_next;
        addr_reg  <= addr_next;
        used_reg  <= used_next;
        v_reg     <= v_next;
        found_reg <= found_next;
        fm_reg    <= fm_next;
        has_reg   <= has_next;
        last_reg  <= last_next;
        slot_reg  <= slot_next;
        off_reg   <= off_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cp_next    = cp_reg;
        req_next   = req_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        mid_next   = mid_reg;
        total_next = total_reg;
        k_next     = k_reg;
        addr_next  = addr_reg;
        used_next  = used_reg;
        v_next     = v_reg;
        found_next = found_reg;
        fm_next    = fm_reg;
        has_next   = has_reg;
        last_next  = last_reg;
        slot_next  = slot_reg;
        off_next   = off_reg;
        ready      = 1'b0;
        out_valid  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                ready = 1'b1;
                if (valid && rt == REQ_LOOKUP)
                begin
                    cp_next    = code_point;
                    req_next   = required_flags;
                    lo_next    = '0;
                    hi_next    = n_eff;
                    state_next = ST_PROBE;
                end
            end
            ST_PROBE:
            begin
                if (lo_reg < hi_reg)
                begin
                    mid_next   = N_W'(lohi >> 1);
                    state_next = ST_CMP;
                end
                else
                begin
                    found_next = 1'b0;
                    fm_next    = 1'b0;
                    total_next = '0;
                    has_next   = 1'b0;
                    v_next     = '0;
                    last_next  = 1'b1;
                    mid_next   = '0;
                    state_next = ST_EMIT;
                end
            end
            ST_CMP:
            begin
                // read of mid issued now from mid_reg; data valid in the info state
                state_next = ST_INFO;
            end
            ST_INFO:
            begin
                if (cp_reg < start_rd)
                begin
                    hi_next    = mid_reg;
                    state_next = ST_PROBE;
                end
                else if ({1'b0, cp_reg} > end_cp)
                begin
                    lo_next    = mid_reg + 1'b1;
                    state_next = ST_PROBE;
                end
                else
                begin
                    found_next = 1'b1;
                    total_next = (32'(cnt_raw) > MAX_MAPPINGS) ? MM_W'(MAX_MAPPINGS)
                                                               : MM_W'(cnt_raw);
                    off_next   = DA_W'(info_rd[CP_W+MAPC_W +: IDX_W]);
                    slot_next  = info_rd[CP_W+MAPC_W+IDX_W +: SLOT_W];
                    state_next = ST_FLAG;
                end
            end
            ST_FLAG:
            begin
                // flag read issued from slot_reg; byte read from off
                addr_next  = off_reg;
                k_next     = '0;
                used_next  = '0;
                v_next     = '0;
                state_next = ST_BYTE;
                if (32'(slot_reg) < FLAG_DEPTH)
                begin
                    fm_next = 1'b1; // resolved next cycle
                end
                else
                begin
                    fm_next = 1'b0;
                end
            end
            ST_BYTE:
            begin
                if (fm_reg && k_reg == '0 && used_reg == '0)
                begin
                    fm_next = (flag_rd & req_reg) == req_reg;
                end
                else if (k_reg == '0 && used_reg == '0)
                begin
                    fm_next = (req_reg == '0);
                end
                if (total_reg == '0)
                begin
                    has_next   = 1'b0;
                    v_next     = '0;
                    last_next  = 1'b1;
                    state_next = ST_EMIT;
                end
                else
                begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                v_next    = CP_W'({v_reg, byte_rd[6:0]});
                used_next = used_reg + 1'b1;
                addr_next = addr_reg + 1'b1;
                if (byte_rd[7] && 32'(used_reg) + 1 < DATA_DEPTH)
                begin
                    state_next = ST_BYTE;
                end
                else
                begin
                    has_next   = 1'b1;
                    last_next  = (k_reg + 1'b1 == total_reg);
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    if (last_reg)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        k_next     = k_reg + 1'b1;
                        used_next  = '0;
                        v_next     = '0;
                        state_next = ST_BYTE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign found         = found_reg;
    assign entry_index   = found_reg ? OUT_IDX_W'(mid_reg) : '0;
    assign flags_match   = found_reg & fm_reg;
    assign mapping_total = found_reg ? MAPC_W'(total_reg) : '0;
    assign has_codepoint = has_reg;
    assign mapped_cp     = has_reg ? v_reg : '0;
    assign last          = last_reg;

    // results only come out of the emit state, never while taking requests
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(ready && out_valid))
        else $error("ready and out_valid both high");
    a_emit_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(mapped_cp) && $stable(last))
        else $error("stalled result changed");
    a_lookup_start: assert property (@(posedge clk) disable iff (!rst_n)
        valid && ready && req_type == REQ_LOOKUP |=> !ready)
        else $error("lookup did not start");
endmodule

// File: tb/tb_top.sv
// Testbench for codepoint_range_map_lookup: a scoreboard class predicts every lookup result
// from its own copy of the range table, flag table and byte store; plain tasks drive the block.
// Depends on crml_pkg and the block's RTL.
module tb_top;
    import crml_pkg::*;

    typedef struct {
        req_type_t   kind;
        logic [15:0] widx;
        logic [20:0] cp;
        logic [20:0] span;
        logic [4:0]  cnt;
        logic [15:0] offset;
        logic [7:0]  slot;
        logic [15:0] fword;
        logic [7:0]  dbyte;
        logic [15:0] need;
    } request_t;

    typedef struct {
        logic        found;
        logic [12:0] idx;
        logic        fmatch;
        logic [4:0]  total;
        logic        has;
        logic [20:0] cp;
        logic        last;
    } lookup_result_t;

    // Keeps its own copy of the stores and predicts lookup results in order.
    class lookup_scoreboard;
        bit [20:0] rstart[8192];
        bit [20:0] rspan[8192];
        bit [4:0]  rcnt[8192];
        bit [15:0] roff[8192];
        bit [7:0]  rslot[8192];
        bit        ent_ok[8192];
        bit [15:0] flags[256];
        bit        flag_ok[256];
        bit [7:0]  mem[65536];
        bit        mem_ok[65536];
        int unsigned    entry_count;
        lookup_result_t pending_q[$];
        int             errors;

        function void push(bit f, bit [12:0] i, bit m, bit [4:0] t, bit h, bit [20:0] c, bit l);
            lookup_result_t r;
            r.found = f; r.idx = i; r.fmatch = m; r.total = t;
            r.has = h; r.cp = c; r.last = l;
            pending_q.push_back(r);
        endfunction

        // Walks a lookup; returns 0 if it would touch a never-written location.
        // With commit set it queues the expected results.
        function bit resolve(request_t q, bit commit);
            int unsigned n, lo, hi, mid, idx, total, addr, used, k, e;
            bit          hit;
            bit [20:0]   v;
            bit [7:0]    b;
            bit          fm;
            n = (entry_count > 8192) ? 8192 : entry_count;
            lo = 0; hi = n; idx = 0; hit = 0;
            while (lo < hi)
            begin
                mid = (lo + hi) / 2;
                if (!ent_ok[mid])
                    return 0;
                e = rstart[mid] + rspan[mid];
                if (q.cp < rstart[mid])
                    hi = mid;
                else if (q.cp > e)
                    lo = mid + 1;
                else
                begin
                    idx = mid;
                    hit = 1;
                    break;
                end
            end
            if (!hit)
            begin
                if (commit)
                    push(0, 0, 0, 0, 0, 0, 1);
                return 1;
            end
            if (!flag_ok[rslot[idx]])
                return 0;
            fm = (flags[rslot[idx]] & q.need) == q.need;
            total = (rcnt[idx] > 18) ? 18 : rcnt[idx];
            addr = roff[idx];
            if (total == 0)
            begin
                if (commit)
                    push(1, idx, fm, 0, 0, 0, 1);
                return 1;
            end
            for (k = 0; k < total; k++)
            begin
                v = 0;
                used = 0;
                do
                begin
                    if (!mem_ok[addr])
                        return 0;
                    b = mem[addr];
                    addr = (addr + 1) % 65536;
                    v = (v << 7) | b[6:0];
                    used++;
                end while (b[7] && used < 65536);
                if (commit)
                    push(1, idx, fm, total, 1, v, k + 1 == total);
            end
            return 1;
        endfunction

        function void note_request(request_t q);
            case (q.kind)
                REQ_WR_ENTRY:
                    if (q.widx < 8192)
                    begin
                        rstart[q.widx] = q.cp;   rspan[q.widx] = q.span;
                        rcnt[q.widx]   = q.cnt;  roff[q.widx]  = q.offset;
                        rslot[q.widx]  = q.slot; ent_ok[q.widx] = 1;
                    end
                REQ_WR_FLAG:
                    if (q.widx < 256)
                    begin
                        flags[q.widx] = q.fword;
                        flag_ok[q.widx] = 1;
                    end
                REQ_WR_BYTE:
                begin
                    mem[q.widx] = q.dbyte;
                    mem_ok[q.widx] = 1;
                end
                default:
                    void'(resolve(q, 1));
            endcase
        endfunction

        function void check_result(lookup_result_t got);
            lookup_result_t want;
            if (pending_q.size() == 0)
            begin
                $error("result with no lookup outstanding");
                errors++;
                return;
            end
            want = pending_q.pop_front();
            if (got.found !== want.found)
            begin
                $error("found: expected %0d, got %0d", want.found, got.found); errors++;
            end
            if (got.idx !== want.idx)
            begin
                $error("entry_index: expected %0d, got %0d", want.idx, got.idx); errors++;
            end
            if (got.fmatch !== want.fmatch)
            begin
                $error("flags_match: expected %0d, got %0d", want.fmatch, got.fmatch); errors++;
            end
            if (got.total !== want.total)
            begin
                $error("mapping_total: expected %0d, got %0d", want.total, got.total); errors++;
            end
            if (got.has !== want.has)
            begin
                $error("has_codepoint: expected %0d, got %0d", want.has, got.has); errors++;
            end
            if (got.cp !== want.cp)
            begin
                $error("mapped_cp: expected 0x%0h, got 0x%0h", want.cp, got.cp); errors++;
            end
            if (got.last !== want.last)
            begin
                $error("last: expected %0d, got %0d", want.last, got.last); errors++;
            end
        endfunction
    endclass

    logic        clk = 0;
    logic        rst_n = 0;
    logic        cfg_we, valid, out_ready;
    logic [13:0] cfg_data;
    logic        ready, out_valid;
    logic [1:0]  req_type;
    logic [15:0] write_index, data_offset, flag_word, required_flags;
    logic [20:0] code_point, range_span, mapped_cp;
    logic [4:0]  map_count, mapping_total;
    logic [7:0]  flag_slot, data_byte;
    logic        found, flags_match, has_codepoint, last;
    logic [12:0] entry_index;

    lookup_scoreboard sb = new();
    int hold_left = 0;   // long receiver hold-off, counted down by the receiver

    codepoint_range_map_lookup DUT (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_data(cfg_data),
        .valid(valid), .ready(ready), .req_type(req_type), .write_index(write_index),
        .code_point(code_point), .range_span(range_span), .map_count(map_count),
        .data_offset(data_offset), .flag_slot(flag_slot), .flag_word(flag_word),
        .data_byte(data_byte), .required_flags(required_flags),
        .out_valid(out_valid), .out_ready(out_ready), .found(found),
        .entry_index(entry_index), .flags_match(flags_match),
        .mapping_total(mapping_total), .has_codepoint(has_codepoint),
        .mapped_cp(mapped_cp), .last(last)
    );

    always #5 clk = ~clk;

    // Result side: capture every accepted result and compare in order.
    always @(posedge clk)
    begin
        lookup_result_t r;
        if (rst_n && out_valid && out_ready)
        begin
            r.found = found; r.idx = entry_index; r.fmatch = flags_match;
            r.total = mapping_total; r.has = has_codepoint; r.cp = mapped_cp;
            r.last = last;
            sb.check_result(r);
        end
    end

    // Receiver stall pattern: the mode is picked at random, from always-ready
    // through light and heavy random stalls; a requested hold-off overrides it.
    initial
    begin
        int cyc;
        int mode;
        out_ready <= 0;
        cyc = 0;
        forever
        begin
            @(posedge clk);
            cyc++;
            if (cyc % 300 == 0)
                mode = $urandom_range(3);
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 0;
            end
            else
                case (mode)
                    0: out_ready <= 1;
                    1: out_ready <= ($urandom_range(9) != 0);
                    2: out_ready <= $urandom_range(1);
                    default: out_ready <= ($urandom_range(3) == 0);
                endcase
        end
    end

    // Watchdog: far beyond the slowest correct run.
    initial
    begin
        #60000000;
        $display("Mismatches found");
        $finish;
    end

    // Present one request and hold it until accepted; valid stays high afterwards.
    task automatic send_request(request_t q);
        valid          <= 1;
        req_type       <= q.kind;
        write_index    <= q.widx;
        code_point     <= q.cp;
        range_span     <= q.span;
        map_count      <= q.cnt;
        data_offset    <= q.offset;
        flag_slot      <= q.slot;
        flag_word      <= q.fword;
        data_byte      <= q.dbyte;
        required_flags <= q.need;
        @(posedge clk);
        while (!ready)
            @(posedge clk);
        sb.note_request(q);
    endtask

    task automatic sender_gap(int cycles);
        valid <= 0;
        repeat (cycles) @(posedge clk);
    endtask

    // Idle until every expected result is back, plus a margin for trailing writes.
    task automatic drain();
        valid <= 0;
        @(posedge clk);
        while (sb.pending_q.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic set_entry_count(logic [13:0] v);
        drain();
        cfg_we   <= 1;
        cfg_data <= v;
        @(posedge clk);
        cfg_we   <= 0;
        sb.entry_count = v;
    endtask

    // Random filler on every field; callers override what matters.
    function automatic request_t noise(req_type_t k);
        request_t q;
        q.kind = k;
        q.widx = $urandom; q.cp = $urandom; q.span = $urandom; q.cnt = $urandom;
        q.offset = $urandom; q.slot = $urandom; q.fword = $urandom;
        q.dbyte = $urandom; q.need = $urandom;
        return q;
    endfunction

    task automatic write_entry(int i, int s, int sp, int c, int off, int sl);
        request_t q;
        q = noise(REQ_WR_ENTRY);
        q.widx = i; q.cp = s; q.span = sp; q.cnt = c; q.offset = off; q.slot = sl;
        send_request(q);
    endtask

    task automatic write_flag(int i, int w);
        request_t q;
        q = noise(REQ_WR_FLAG);
        q.widx = i; q.fword = w;
        send_request(q);
    endtask

    task automatic write_byte(int a, int b);
        request_t q;
        q = noise(REQ_WR_BYTE);
        q.widx = a; q.dbyte = b;
        send_request(q);
    endtask

    // Lookups that would read a never-written location are dropped; valid goes low
    // for a cycle so the previous request is not offered again.
    task automatic lookup(int c, int need);
        request_t q;
        q = noise(REQ_LOOKUP);
        q.cp = c; q.need = need;
        if (sb.resolve(q, 0))
            send_request(q);
        else
            sender_gap(1);
    endtask

    function automatic int pick_byte();
        int b;
        b = $urandom_range(255);
        if (b[7] && $urandom_range(9) < 7)
            b[7] = 0;
        return b;
    endfunction

    function automatic int span_room(int i);
        if (i == 15)
            return 21'h10FFFF - sb.rstart[15];
        return sb.rstart[i + 1] - sb.rstart[i] - 1;
    endfunction

    // One random request against the 16-entry table: mostly lookups, some writes.
    function automatic request_t random_request();
        request_t q;
        int       i, sel, n, tries;
        sel = $urandom_range(99);
        if (sel < 10)
        begin
            q = noise(REQ_WR_ENTRY);
            i = $urandom_range(15);
            q.widx = ($urandom_range(9) == 0) ? $urandom_range(65535, 8192) : i;
            q.cp = sb.rstart[i];
            q.span = $urandom_range(span_room(i));
            q.cnt = ($urandom_range(9) < 7) ? $urandom_range(4) : $urandom_range(31);
            q.offset = ($urandom_range(9) == 0) ? $urandom_range(65535, 65532)
                                                : $urandom_range(40);
            q.slot = $urandom_range(7);
            return q;
        end
        if (sel < 16)
        begin
            q = noise(REQ_WR_FLAG);
            q.widx = ($urandom_range(9) == 0) ? $urandom_range(65535, 256) : $urandom_range(7);
            return q;
        end
        if (sel < 26)
        begin
            q = noise(REQ_WR_BYTE);
            q.widx = $urandom_range(63);
            q.dbyte = pick_byte();
            return q;
        end
        n = (sb.entry_count > 16) ? 16 : sb.entry_count;
        for (tries = 0; tries < 20; tries++)
        begin
            q = noise(REQ_LOOKUP);
            if (n > 0 && $urandom_range(99) < 70)
            begin
                i = $urandom_range(n - 1);
                q.cp = sb.rstart[i] + $urandom_range(sb.rspan[i]);
            end
            else
                q.cp = $urandom_range(21'h10FFFF);
            case ($urandom_range(2))
                0: q.need = 0;
                1: q.need = $urandom & $urandom & 16'hFFFF;
                default: q.need = $urandom;
            endcase
            if (sb.resolve(q, 0))
                return q;
        end
        q = noise(REQ_WR_FLAG);
        q.widx = $urandom_range(7);
        return q;
    endfunction

    initial
    begin
        int phase_counts[5] = '{16, 1, 9, 5, 16};
        int p, k, i, burst, cursor;
        request_t q;

        cfg_we <= 0; cfg_data <= 0; valid <= 0;
        req_type <= REQ_LOOKUP; write_index <= 0; code_point <= 0; range_span <= 0;
        map_count <= 0; data_offset <= 0; flag_slot <= 0; flag_word <= 0;
        data_byte <= 0; required_flags <= 0;
        repeat (2) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Empty table after reset: a lookup finds nothing.
        lookup(21'h10FFFF, 16'hFFFF);
        sender_gap(1);

        // Stores: flag words, a data region and the top bytes for address wrap.
        write_flag(0, 16'hFFFF);
        write_flag(1, 16'h0000);
        for (i = 2; i < 8; i++)
            write_flag(i, $urandom);
        write_flag(256, 16'h1234);
        write_flag(65535, 16'hFFFF);
        for (i = 0; i < 64; i++)
            write_byte(i, pick_byte());
        for (i = 65532; i < 65536; i++)
            write_byte(i, 8'h80 | $urandom_range(127));

        // Sorted 16-entry table from codepoint 0 up to the top of the range.
        cursor = 0;
        for (i = 0; i < 16; i++)
        begin
            sb.rstart[i] = cursor;
            write_entry(i, cursor, (i == 15) ? 21'h10FFFF - cursor : $urandom_range(3000),
                        $urandom_range(4), $urandom_range(40), $urandom_range(7));
            cursor = sb.rstart[i] + sb.rspan[i] + 1 + $urandom_range(5000);
        end
        // Entries with no mappings, the full count, an oversized count, wrapped data and out-of-range indexes.
        write_entry(1, sb.rstart[1], sb.rspan[1], 0, 0, 0);
        write_entry(2, sb.rstart[2], sb.rspan[2], 18, 0, 0);
        write_entry(3, sb.rstart[3], sb.rspan[3], 31, 40, 1);
        write_entry(4, sb.rstart[4], sb.rspan[4], 2, 65533, 2);
        write_entry(8192, 0, 0, 0, 0, 0);
        write_entry(65535, 21'h1FFFFF, 21'h1FFFFF, 31, 65535, 255);

        set_entry_count(16);
        lookup(0, 16'h0000);
        lookup(21'h10FFFF, 16'hFFFF);
        lookup(sb.rstart[15] - 1, 16'h0001);
        lookup(sb.rstart[1], 16'h00F0);
        lookup(sb.rstart[2] + sb.rspan[2], 16'hFFFF);
        lookup(sb.rstart[3], 16'h0001);
        lookup(sb.rstart[3], 16'h0000);
        lookup(sb.rstart[4], $urandom);
        lookup(sb.rstart[7] + sb.rspan[7] + 1, 0);

        // Random phases over several table sizes, bursts with gaps on the send side.
        for (p = 0; p < 5; p++)
        begin
            set_entry_count(phase_counts[p]);
            k = 0;
            while (k < 40)
            begin
                burst = $urandom_range(12, 1);
                while (burst > 0 && k < 40)
                begin
                    q = random_request();
                    send_request(q);
                    burst--;
                    k++;
                    if (p == 0 && k == 10)
                        hold_left = 400;   // receiver holds off; the block backs up
                    if (p == 0 && k == 30)
                    begin
                        valid <= 0;
                        @(posedge clk);
                        while (sb.pending_q.size() != 0)
                            @(posedge clk);
                    end
                end
                if ($urandom_range(3) != 0)
                    sender_gap($urandom_range(8, 1));
            end
        end

        // Full-depth table under the largest count setting, written along the search
        // paths of the lookups below; the search is capped at the depth.
        drain();
        write_entry(0, 0, $urandom_range(135), $urandom_range(3),
                    $urandom_range(40), $urandom_range(7));
        for (i = 1; i < 8192; i = i * 2)
        begin
            write_entry(i, i * 136, $urandom_range(135), $urandom_range(3),
                        $urandom_range(40), $urandom_range(7));
            write_entry(8192 - i, (8192 - i) * 136, $urandom_range(135), $urandom_range(3),
                        $urandom_range(40), $urandom_range(7));
        end
        set_entry_count(14'h3FFF);
        for (i = 1; i < 8192; i = i * 2)
        begin
            lookup(i * 136, $urandom & $urandom);
            lookup((8192 - i) * 136 + $urandom_range(135), 0);
        end
        lookup(0, 0);
        lookup(21'h10FFFF, 0);

        drain();
        repeat (100) @(posedge clk);
        if (sb.errors == 0 && sb.pending_q.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule

// File: filelist.f
src/crml_pkg.sv
src/crml_ram.sv
src/codepoint_range_map_lookup.sv
tb/tb_top.sv
